>>> rtl/core/x86ex_pkg.sv
// Package for the i386 subset executor: item, result and state types,
// opcode constants and the shared helpers for access checks and sign extension.
// No dependencies.
`default_nettype none
package x86ex_pkg;

  localparam int RAM_BYTES_DEF = 65536;
  localparam int LOW_GUARD_DEF = 4096;
  localparam int FQ_DEPTH      = 2;

  localparam logic [15:0] ENTRY_RST = 16'd4096;
  localparam logic [16:0] LIMIT_RST = 17'd65536;

  localparam logic CFG_ENTRY = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  localparam logic [7:0] OPC_0F    = 8'd15;
  localparam logic [7:0] OPC_SUBM  = 8'd41;
  localparam logic [7:0] OPC_PUSHA = 8'd80;
  localparam logic [7:0] OPC_POPA  = 8'd88;
  localparam logic [7:0] OPC_POPC  = 8'd89;
  localparam logic [7:0] OPC_POPD  = 8'd90;
  localparam logic [7:0] OPC_POPB  = 8'd91;
  localparam logic [7:0] OPC_JZ    = 8'd116;
  localparam logic [7:0] OPC_JNZ   = 8'd117;
  localparam logic [7:0] OPC_SUBI  = 8'd129;
  localparam logic [7:0] OPC_TEST  = 8'd133;
  localparam logic [7:0] OPC_XCHG  = 8'd135;
  localparam logic [7:0] OPC_MOVB  = 8'd136;
  localparam logic [7:0] OPC_MOVSP = 8'd137;
  localparam logic [7:0] OPC_LDW   = 8'd139;
  localparam logic [7:0] OPC_POPM  = 8'd143;
  localparam logic [7:0] OPC_MOVI  = 8'd184;
  localparam logic [7:0] OPC_RET   = 8'd195;
  localparam logic [7:0] OPC_INT   = 8'd205;
  localparam logic [7:0] OPC_CALL  = 8'd232;
  localparam logic [7:0] OPC_DEC   = 8'd254;

  localparam logic [7:0] SUB_SETGE = 8'd157;
  localparam logic [7:0] SUB_MOVZB = 8'd182;
  localparam logic [7:0] SUB_MOVSB = 8'd190;
  localparam logic [7:0] MODRM_AL  = 8'd192;
  localparam logic [7:0] MODRM_SP  = 8'd4;
  localparam logic [7:0] SIB_SP    = 8'd36;
  localparam logic [7:0] MODRM_BP  = 8'd237;
  localparam logic [7:0] MODRM_XCH = 8'd236;
  localparam logic [7:0] MODRM_CL  = 8'd8;
  localparam logic [7:0] MODRM_MOV = 8'd229;
  localparam logic [7:0] MODRM_EAX = 8'd0;
  localparam logic [7:0] INT_VEC   = 8'h80;
  localparam logic [7:0] MODRM_DEC = 8'd200;

  localparam logic [31:0] SYS_EXIT  = 32'd1;
  localparam logic [31:0] SYS_READ  = 32'd3;
  localparam logic [31:0] SYS_WRITE = 32'd4;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_OK      = 4'd0,
    ST_EXIT    = 4'd1,
    ST_READ    = 4'd2,
    ST_WRITE   = 4'd3,
    ST_LIMIT   = 4'd4,
    ST_ZPAGE   = 4'd5,
    ST_BADINSN = 4'd6,
    ST_BADSYS  = 4'd7,
    ST_HALTED  = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_DECODE, S_MRD, S_MWR, S_COMMIT, S_DONE
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] addr;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] pc;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } result_t;

  function automatic status_e check_access(logic [31:0] addr, logic [32:0] len,
                                           logic [32:0] lim, logic [32:0] guard);
    logic [33:0] endp;
    endp = {2'b00, addr} + {1'b0, len};
    if ({1'b0, addr} > lim || endp > {1'b0, lim}) return ST_LIMIT;
    if ({1'b0, addr} < guard) return ST_ZPAGE;
    return ST_OK;
  endfunction

  function automatic logic [31:0] sext8(logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/x86ex_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module x86ex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

>>> rtl/core/x86ex_front.sv
// Front end: takes items from the input port, classifies the operation
// and buffers them in a short queue for the back end. Uses x86ex_pkg.
`default_nettype none
module x86ex_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire logic [1:0]      operation_i,
  input  wire logic [15:0]     load_address_i,
  input  wire logic [7:0]      load_byte_i,
  input  wire logic            hold_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output x86ex_pkg::item_t     head_o,
  output logic                 empty_o
);

  localparam int PW = $clog2(x86ex_pkg::FQ_DEPTH);
  localparam int CW = $clog2(x86ex_pkg::FQ_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(x86ex_pkg::FQ_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(x86ex_pkg::FQ_DEPTH);

  x86ex_pkg::item_t slot_q [x86ex_pkg::FQ_DEPTH];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == DEPTH_C) || hold_i;
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) wptr_d = (wptr_q == LAST) ? '0 : wptr_q + 1'b1;
    if (do_pop)  rptr_d = (rptr_q == LAST) ? '0 : rptr_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= '{op: x86ex_pkg::op_e'(operation_i),
                          addr: load_address_i, data: load_byte_i};
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/x86ex_back.sv
// Back end: sequencer that executes one item at a time against the byte
// memory and the register file. Uses x86ex_pkg and x86ex_ram.
`default_nettype none
module x86ex_back #(
  parameter int RAM_BYTES = x86ex_pkg::RAM_BYTES_DEF,
  parameter int LOW_GUARD = x86ex_pkg::LOW_GUARD_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [15:0]       entry_i,
  input  wire logic [16:0]       limit_i,
  input  wire x86ex_pkg::item_t  item_i,
  input  wire logic              item_valid_i,
  output logic                   item_pop_o,
  output logic                   clearing_o,
  output x86ex_pkg::result_t     res_o,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i
);

  localparam int AW = $clog2(RAM_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(RAM_BYTES - 1);
  localparam logic [32:0] RAM_LIM = 33'(RAM_BYTES);
  localparam logic [32:0] GUARD = 33'(LOW_GUARD);

  x86ex_pkg::state_e state_q, state_d;
  x86ex_pkg::status_e status_q, status_d;
  logic [31:0] a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d;
  logic [31:0] sp_q, sp_d, fp_q, fp_d, pc_q, pc_d;
  logic zf_q, zf_d, sf_q, sf_d, of_q, of_d, halted_q, halted_d;
  logic [7:0] ib_q [6];
  logic [7:0] ib_d [6];
  logic [31:0] rbuf_q, rbuf_d;
  logic [2:0] cnt_q, cnt_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [31:0] mrd_addr_q, mrd_addr_d, mwr_addr_q, mwr_addr_d;
  logic [2:0] mrd_len_q, mrd_len_d, mwr_len_q, mwr_len_d;

  logic ram_we;
  logic [31:0] maddr;
  logic [7:0] ram_wdata, ram_rdata;

  logic [32:0] lim;
  x86ex_pkg::status_e ck_pc, ck_sp, ck_spm, ck_a1, ck_a4, ck_cd;
  x86ex_pkg::status_e dec_st;
  logic [2:0] dec_rlen, dec_wlen;
  logic [31:0] dec_raddr, dec_waddr;
  logic dec_fault;
  logic [31:0] wdat, imm_lo, imm_hi, sub_r, sub_i;

  assign lim = ({16'b0, limit_i} < RAM_LIM) ? {16'b0, limit_i} : RAM_LIM;
  assign ck_pc  = x86ex_pkg::check_access(pc_q, 33'd6, lim, GUARD);
  assign ck_sp  = x86ex_pkg::check_access(sp_q, 33'd4, lim, GUARD);
  assign ck_spm = x86ex_pkg::check_access(sp_q - 32'd4, 33'd4, lim, GUARD);
  assign ck_a1  = x86ex_pkg::check_access(a_q, 33'd1, lim, GUARD);
  assign ck_a4  = x86ex_pkg::check_access(a_q, 33'd4, lim, GUARD);
  assign ck_cd  = x86ex_pkg::check_access(c_q, {1'b0, d_q}, lim, GUARD);

  assign imm_lo = {ib_q[4], ib_q[3], ib_q[2], ib_q[1]};
  assign imm_hi = {ib_q[5], ib_q[4], ib_q[3], ib_q[2]};
  assign sub_r  = rbuf_q - a_q;
  assign sub_i  = fp_q - imm_hi;

  x86ex_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (maddr[AW-1:0]),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // operand needs and faults of the fetched instruction, in model order
  always_comb begin : decode
    dec_st    = x86ex_pkg::ST_OK;
    dec_rlen  = 3'd0;
    dec_wlen  = 3'd0;
    dec_raddr = sp_q;
    dec_waddr = sp_q;
    unique case (ib_q[0])
      x86ex_pkg::OPC_0F: begin
        if (ib_q[1] == x86ex_pkg::SUB_SETGE && ib_q[2] == x86ex_pkg::MODRM_AL) begin
          dec_st = x86ex_pkg::ST_OK;
        end else if (ib_q[1] == x86ex_pkg::SUB_MOVZB && ib_q[2] == x86ex_pkg::MODRM_EAX) begin
          dec_st = ck_a1; dec_rlen = 3'd1; dec_raddr = a_q;
        end else if (ib_q[1] == x86ex_pkg::SUB_MOVSB && ib_q[2] == x86ex_pkg::MODRM_AL) begin
          dec_st = x86ex_pkg::ST_OK;
        end else begin
          dec_st = x86ex_pkg::ST_BADINSN;
        end
      end
      x86ex_pkg::OPC_SUBM: begin
        if (ib_q[1] != x86ex_pkg::MODRM_SP || ib_q[2] != x86ex_pkg::SIB_SP)
          dec_st = x86ex_pkg::ST_BADINSN;
        else dec_st = ck_sp;
        dec_rlen = 3'd4; dec_wlen = 3'd4;
      end
      x86ex_pkg::OPC_PUSHA, x86ex_pkg::OPC_CALL: begin
        dec_st = ck_spm; dec_wlen = 3'd4; dec_waddr = sp_q - 32'd4;
      end
      x86ex_pkg::OPC_POPA, x86ex_pkg::OPC_POPC, x86ex_pkg::OPC_POPD,
      x86ex_pkg::OPC_POPB, x86ex_pkg::OPC_RET: begin
        dec_st = ck_sp; dec_rlen = 3'd4;
      end
      x86ex_pkg::OPC_JZ, x86ex_pkg::OPC_JNZ, x86ex_pkg::OPC_MOVI: dec_st = x86ex_pkg::ST_OK;
      x86ex_pkg::OPC_SUBI:
        if (ib_q[1] != x86ex_pkg::MODRM_BP) dec_st = x86ex_pkg::ST_BADINSN;
      x86ex_pkg::OPC_TEST:
        if (ib_q[1] != x86ex_pkg::MODRM_AL) dec_st = x86ex_pkg::ST_BADINSN;
      x86ex_pkg::OPC_XCHG:
        if (ib_q[1] != x86ex_pkg::MODRM_XCH) dec_st = x86ex_pkg::ST_BADINSN;
      x86ex_pkg::OPC_MOVB: begin
        if (ib_q[1] != x86ex_pkg::MODRM_CL) dec_st = x86ex_pkg::ST_BADINSN;
        else dec_st = ck_a1;
        dec_wlen = 3'd1; dec_waddr = a_q;
      end
      x86ex_pkg::OPC_MOVSP:
        if (ib_q[1] != x86ex_pkg::MODRM_MOV) dec_st = x86ex_pkg::ST_BADINSN;
      x86ex_pkg::OPC_LDW: begin
        if (ib_q[1] != x86ex_pkg::MODRM_EAX) dec_st = x86ex_pkg::ST_BADINSN;
        else dec_st = ck_a4;
        dec_rlen = 3'd4; dec_raddr = a_q;
      end
      x86ex_pkg::OPC_POPM: begin
        if (ib_q[1] != x86ex_pkg::MODRM_EAX) dec_st = x86ex_pkg::ST_BADINSN;
        else if (ck_sp != x86ex_pkg::ST_OK) dec_st = ck_sp;
        else dec_st = ck_a4;
        dec_rlen = 3'd4; dec_wlen = 3'd4; dec_waddr = a_q;
      end
      x86ex_pkg::OPC_INT: begin
        if (ib_q[1] != x86ex_pkg::INT_VEC) dec_st = x86ex_pkg::ST_BADINSN;
        else if (a_q == x86ex_pkg::SYS_EXIT) dec_st = x86ex_pkg::ST_EXIT;
        else if (a_q != x86ex_pkg::SYS_READ && a_q != x86ex_pkg::SYS_WRITE)
          dec_st = x86ex_pkg::ST_BADSYS;
        else if (ck_cd != x86ex_pkg::ST_OK) dec_st = ck_cd;
        else if (a_q == x86ex_pkg::SYS_READ) dec_st = x86ex_pkg::ST_READ;
        else dec_st = x86ex_pkg::ST_WRITE;
      end
      x86ex_pkg::OPC_DEC:
        if (ib_q[1] != x86ex_pkg::MODRM_DEC) dec_st = x86ex_pkg::ST_BADINSN;
      default: dec_st = x86ex_pkg::ST_BADINSN;
    endcase
  end

  assign dec_fault = (dec_st >= x86ex_pkg::ST_LIMIT);

  // store data for the write phase
  always_comb begin
    unique case (ib_q[0])
      x86ex_pkg::OPC_SUBM:  wdat = sub_r;
      x86ex_pkg::OPC_POPM:  wdat = rbuf_q;
      x86ex_pkg::OPC_CALL:  wdat = pc_q + 32'd5;
      x86ex_pkg::OPC_MOVB:  wdat = {24'b0, c_q[7:0]};
      default:              wdat = a_q;
    endcase
  end

  always_comb begin : next_state
    state_d = state_q;
    unique case (state_q)
      x86ex_pkg::S_CLEAR: if (clr_q == CLR_LAST) state_d = x86ex_pkg::S_IDLE;
      x86ex_pkg::S_IDLE:
        if (item_valid_i) begin
          if (item_i.op == x86ex_pkg::OP_STEP && !halted_q && ck_pc == x86ex_pkg::ST_OK)
            state_d = x86ex_pkg::S_FETCH;
          else state_d = x86ex_pkg::S_DONE;
        end
      x86ex_pkg::S_FETCH: if (cnt_q == 3'd6) state_d = x86ex_pkg::S_DECODE;
      x86ex_pkg::S_DECODE:
        if (dec_fault) state_d = x86ex_pkg::S_DONE;
        else if (dec_rlen != 3'd0) state_d = x86ex_pkg::S_MRD;
        else if (dec_wlen != 3'd0) state_d = x86ex_pkg::S_MWR;
        else state_d = x86ex_pkg::S_COMMIT;
      x86ex_pkg::S_MRD:
        if (cnt_q == mrd_len_q)
          state_d = (mwr_len_q != 3'd0) ? x86ex_pkg::S_MWR : x86ex_pkg::S_COMMIT;
      x86ex_pkg::S_MWR: if (cnt_q == mwr_len_q - 3'd1) state_d = x86ex_pkg::S_COMMIT;
      x86ex_pkg::S_COMMIT: state_d = x86ex_pkg::S_DONE;
      x86ex_pkg::S_DONE: if (res_ready_i) state_d = x86ex_pkg::S_IDLE;
      default: state_d = x86ex_pkg::S_IDLE;
    endcase
  end

  always_comb begin : datapath
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q;
    sp_d = sp_q; fp_d = fp_q; pc_d = pc_q;
    zf_d = zf_q; sf_d = sf_q; of_d = of_q; halted_d = halted_q;
    status_d = status_q;
    ib_d = ib_q;
    rbuf_d = rbuf_q;
    clr_d = clr_q;
    mrd_addr_d = mrd_addr_q; mrd_len_d = mrd_len_q;
    mwr_addr_d = mwr_addr_q; mwr_len_d = mwr_len_q;
    cnt_d = (state_d != state_q) ? 3'd0 : cnt_q + 3'd1;
    ram_we = 1'b0;
    maddr = pc_q + 32'(cnt_q);
    ram_wdata = 8'd0;
    item_pop_o = 1'b0;
    unique case (state_q)
      x86ex_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        maddr = 32'(clr_q);
        clr_d = clr_q + 1'b1;
      end
      x86ex_pkg::S_IDLE: begin
        maddr = {16'b0, item_i.addr};
        ram_wdata = item_i.data;
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          status_d = x86ex_pkg::ST_OK;
          unique case (item_i.op)
            x86ex_pkg::OP_LOAD: ram_we = ({16'b0, item_i.addr} < 32'(RAM_BYTES));
            x86ex_pkg::OP_START: begin
              pc_d = {16'b0, entry_i};
              sp_d = {15'b0, limit_i};
              fp_d = {15'b0, limit_i};
              a_d = '0; b_d = '0; c_d = '0; d_d = '0;
              zf_d = 1'b0; sf_d = 1'b0; of_d = 1'b0;
              halted_d = 1'b0;
            end
            x86ex_pkg::OP_STEP:
              if (halted_q) status_d = x86ex_pkg::ST_HALTED;
              else if (ck_pc != x86ex_pkg::ST_OK) begin
                status_d = ck_pc;
                halted_d = 1'b1;
              end
            default: status_d = x86ex_pkg::ST_OK;
          endcase
        end
      end
      x86ex_pkg::S_FETCH: begin
        if (cnt_q != 3'd0) ib_d[cnt_q - 3'd1] = ram_rdata;
      end
      x86ex_pkg::S_DECODE: begin
        status_d = dec_st;
        if (dec_fault) halted_d = 1'b1;
        rbuf_d = '0;
        mrd_addr_d = dec_raddr; mrd_len_d = dec_rlen;
        mwr_addr_d = dec_waddr; mwr_len_d = dec_wlen;
      end
      x86ex_pkg::S_MRD: begin
        maddr = mrd_addr_q + 32'(cnt_q);
        if (cnt_q != 3'd0) rbuf_d[8*(cnt_q[1:0] - 2'd1) +: 8] = ram_rdata;
      end
      x86ex_pkg::S_MWR: begin
        maddr = mwr_addr_q + 32'(cnt_q);
        ram_we = 1'b1;
        ram_wdata = wdat[8*cnt_q[1:0] +: 8];
      end
      x86ex_pkg::S_COMMIT: begin
        unique case (ib_q[0])
          x86ex_pkg::OPC_0F: begin
            pc_d = pc_q + 32'd3;
            if (ib_q[1] == x86ex_pkg::SUB_SETGE) a_d = {a_q[31:8], 7'b0, (sf_q == of_q)};
            else if (ib_q[1] == x86ex_pkg::SUB_MOVZB) a_d = rbuf_q;
            else a_d = x86ex_pkg::sext8(a_q[7:0]);
          end
          x86ex_pkg::OPC_SUBM: begin
            pc_d = pc_q + 32'd3;
            zf_d = (sub_r == 32'd0);
            sf_d = sub_r[31];
            of_d = ((rbuf_q[31] ^ a_q[31]) & (rbuf_q[31] ^ sub_r[31]));
          end
          x86ex_pkg::OPC_PUSHA: begin
            sp_d = sp_q - 32'd4; pc_d = pc_q + 32'd1;
          end
          x86ex_pkg::OPC_POPA, x86ex_pkg::OPC_POPC, x86ex_pkg::OPC_POPD,
          x86ex_pkg::OPC_POPB: begin
            sp_d = sp_q + 32'd4; pc_d = pc_q + 32'd1;
            if (ib_q[0] == x86ex_pkg::OPC_POPA) a_d = rbuf_q;
            else if (ib_q[0] == x86ex_pkg::OPC_POPC) c_d = rbuf_q;
            else if (ib_q[0] == x86ex_pkg::OPC_POPD) d_d = rbuf_q;
            else b_d = rbuf_q;
          end
          x86ex_pkg::OPC_JZ, x86ex_pkg::OPC_JNZ:
            pc_d = pc_q + 32'd2 +
                   (((ib_q[0] == x86ex_pkg::OPC_JZ) == zf_q) ? x86ex_pkg::sext8(ib_q[1]) : 32'd0);
          x86ex_pkg::OPC_SUBI: begin
            fp_d = sub_i; pc_d = pc_q + 32'd6;
            zf_d = (sub_i == 32'd0);
            sf_d = sub_i[31];
            of_d = ((fp_q[31] ^ imm_hi[31]) & (fp_q[31] ^ sub_i[31]));
          end
          x86ex_pkg::OPC_TEST: begin
            zf_d = (a_q == 32'd0); sf_d = a_q[31]; of_d = 1'b0;
            pc_d = pc_q + 32'd2;
          end
          x86ex_pkg::OPC_XCHG: begin
            fp_d = sp_q; sp_d = fp_q; pc_d = pc_q + 32'd2;
          end
          x86ex_pkg::OPC_MOVSP: begin
            fp_d = sp_q; pc_d = pc_q + 32'd2;
          end
          x86ex_pkg::OPC_LDW: begin
            a_d = rbuf_q; pc_d = pc_q + 32'd2;
          end
          x86ex_pkg::OPC_POPM: begin
            sp_d = sp_q + 32'd4; pc_d = pc_q + 32'd2;
          end
          x86ex_pkg::OPC_MOVI: begin
            a_d = imm_lo; pc_d = pc_q + 32'd5;
          end
          x86ex_pkg::OPC_RET: begin
            pc_d = rbuf_q; sp_d = sp_q + 32'd4;
          end
          x86ex_pkg::OPC_INT: begin
            pc_d = pc_q + 32'd2;
            if (status_q == x86ex_pkg::ST_EXIT) halted_d = 1'b1;
          end
          x86ex_pkg::OPC_CALL: begin
            sp_d = sp_q - 32'd4; pc_d = pc_q + 32'd5 + imm_lo;
          end
          x86ex_pkg::OPC_DEC: begin
            a_d[7:0] = a_q[7:0] - 8'd1;
            zf_d = (a_q[7:0] == 8'd1);
            sf_d = a_d[7];
            of_d = (a_q[7:0] == 8'h80);
            pc_d = pc_q + 32'd2;
          end
          default: pc_d = pc_q + 32'd2;  // MOVB: store already done
        endcase
      end
      default: ;
    endcase
  end

  assign clearing_o  = (state_q == x86ex_pkg::S_CLEAR);
  assign res_valid_o = (state_q == x86ex_pkg::S_DONE);
  assign res_o = '{status: status_q, pc: pc_q, a: a_q, b: b_q, c: c_q, d: d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= x86ex_pkg::S_CLEAR;
      status_q <= x86ex_pkg::ST_OK;
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
      sp_q <= '0; fp_q <= '0; pc_q <= '0;
      zf_q <= 1'b0; sf_q <= 1'b0; of_q <= 1'b0;
      halted_q <= 1'b1;
      cnt_q <= '0;
      clr_q <= '0;
    end else begin
      state_q <= state_d;
      status_q <= status_d;
      a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d;
      sp_q <= sp_d; fp_q <= fp_d; pc_q <= pc_d;
      zf_q <= zf_d; sf_q <= sf_d; of_q <= of_d;
      halted_q <= halted_d;
      cnt_q <= cnt_d;
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ib_q <= ib_d;
    rbuf_q <= rbuf_d;
    mrd_addr_q <= mrd_addr_d; mrd_len_q <= mrd_len_d;
    mwr_addr_q <= mwr_addr_d; mwr_len_q <= mwr_len_d;
  end

  a_fetch_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == x86ex_pkg::S_FETCH || state_q == x86ex_pkg::S_MRD) |-> !ram_we)
    else $error("memory write during a read phase");

  a_rd_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == x86ex_pkg::S_MRD) |-> (mrd_len_q == 3'd1 || mrd_len_q == 3'd4))
    else $error("bad read length");

  a_fault_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status >= x86ex_pkg::ST_LIMIT) |=> halted_q)
    else $error("fault did not halt");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |-> (state_q == x86ex_pkg::S_IDLE && item_valid_i))
    else $error("item taken while busy");

endmodule
`default_nettype wire

>>> rtl/core/x86_subset_instruction_executor_unit.sv
// Load, start, halted and fetch-fault steps pass from the idle state straight to the done
// state; an executed step fetches 6 bytes, decodes, reads up to 4 bytes and writes up to
// 4 on the single-port byte memory. One item in work at a time; a 2-entry input queue and
// an output register decouple both sides.
// After reset the memory is cleared, with full held high.
// Top level: configuration registers, front queue, back end, result register.
`default_nettype none
module x86_subset_instruction_executor_unit #(
  parameter int RAM_BYTES = x86ex_pkg::RAM_BYTES_DEF,
  parameter int LOW_GUARD = x86ex_pkg::LOW_GUARD_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  operation_i,
  input  wire logic [15:0] load_address_i,
  input  wire logic [7:0]  load_byte_i,
  input  wire logic        pop,
  output logic             empty,
  output logic [3:0]       status_o,
  output logic [31:0]      instr_addr_o,
  output logic [31:0]      acc_value_o,
  output logic [31:0]      arg_b_o,
  output logic [31:0]      arg_c_o,
  output logic [31:0]      arg_d_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [16:0] cfg_data_i
);

  logic [15:0] entry_q;
  logic [16:0] limit_q;
  x86ex_pkg::item_t head;
  logic head_empty, head_pop, clearing;
  x86ex_pkg::result_t res, out_q;
  logic res_valid, res_ready, out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= x86ex_pkg::ENTRY_RST;
      limit_q <= x86ex_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        x86ex_pkg::CFG_ENTRY: entry_q <= cfg_data_i[15:0];
        x86ex_pkg::CFG_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  x86ex_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .operation_i    (operation_i),
    .load_address_i (load_address_i),
    .load_byte_i    (load_byte_i),
    .hold_i         (clearing),
    .full_o         (full),
    .pop_i          (head_pop),
    .head_o         (head),
    .empty_o        (head_empty)
  );

  x86ex_back #(.RAM_BYTES(RAM_BYTES), .LOW_GUARD(LOW_GUARD)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (entry_q),
    .limit_i      (limit_q),
    .item_i       (head),
    .item_valid_i (!head_empty),
    .item_pop_o   (head_pop),
    .clearing_o   (clearing),
    .res_o        (res),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready)
  );

  assign res_ready = !out_valid_q || pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign empty        = !out_valid_q;
  assign status_o     = out_q.status;
  assign instr_addr_o = out_q.pc;
  assign acc_value_o  = out_q.a;
  assign arg_b_o      = out_q.b;
  assign arg_c_o      = out_q.c;
  assign arg_d_o      = out_q.d;

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the i386 subset executor: small programs are loaded,
// started and stepped, and each result is checked against an in-bench instruction model.
// Depends on x86ex_pkg and x86_subset_instruction_executor_unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import x86ex_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  operation_i = '0;
  logic [15:0] load_address_i = '0;
  logic [7:0]  load_byte_i = '0;
  logic        pop = 1'b0;
  logic        empty;
  logic [3:0]  status_o;
  logic [31:0] instr_addr_o, acc_value_o, arg_b_o, arg_c_o, arg_d_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [16:0] cfg_data_i = '0;

  x86_subset_instruction_executor_unit dut (
    .clk_i, .rst_ni, .push, .full, .operation_i, .load_address_i, .load_byte_i,
    .pop, .empty, .status_o, .instr_addr_o, .acc_value_o, .arg_b_o, .arg_c_o,
    .arg_d_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow CPU state
  logic [7:0]  mem [0:65535];
  logic [31:0] ra, rb, rc, rd, sp, fp, pc;
  logic        zf, sf, of, hlt;
  logic [15:0] entry_r;
  logic [16:0] limit_r;

  result_t     exp_q[$];
  logic [7:0]  prog_q[$];
  int          err_cnt = 0;
  int          items_sent = 0;
  int          send_idle = 28;
  int          recv_idle = 57;
  int          hold_left = 0;

  function automatic status_e range_chk(logic [31:0] a, logic [31:0] n);
    longint unsigned lim;
    lim = (limit_r < RAM_BYTES_DEF) ? limit_r : RAM_BYTES_DEF;
    if (longint'(a) > lim || longint'(a) + longint'(n) > lim) return ST_LIMIT;
    if (longint'(a) < LOW_GUARD_DEF) return ST_ZPAGE;
    return ST_OK;
  endfunction

  function automatic logic [31:0] rd_word(logic [31:0] a);
    return {mem[a[15:0] + 16'd3], mem[a[15:0] + 16'd2], mem[a[15:0] + 16'd1], mem[a[15:0]]};
  endfunction

  function automatic void wr_word(logic [31:0] a, logic [31:0] v);
    mem[a[15:0]] = v[7:0];
    mem[a[15:0] + 16'd1] = v[15:8];
    mem[a[15:0] + 16'd2] = v[23:16];
    mem[a[15:0] + 16'd3] = v[31:24];
  endfunction

  function automatic void sub_flags(logic [31:0] x, logic [31:0] y, logic [31:0] r);
    zf = (r == 32'd0);
    sf = r[31];
    of = (x[31] ^ y[31]) & (x[31] ^ r[31]);
  endfunction

  function automatic status_e exec_instr();
    logic [31:0] t, v;
    logic [7:0]  b0, b1, b2;
    status_e     st;
    st = range_chk(pc, 32'd6);
    if (st != ST_OK) return st;
    b0 = mem[pc[15:0]];
    b1 = mem[pc[15:0] + 16'd1];
    b2 = mem[pc[15:0] + 16'd2];
    case (b0)
      OPC_0F: begin
        if (b1 == SUB_SETGE && b2 == MODRM_AL) begin
          ra = {ra[31:8], 7'd0, sf == of};
        end else if (b1 == SUB_MOVZB && b2 == MODRM_EAX) begin
          st = range_chk(ra, 32'd1);
          if (st != ST_OK) return st;
          ra = {24'd0, mem[ra[15:0]]};
        end else if (b1 == SUB_MOVSB && b2 == MODRM_AL) begin
          ra = {{24{ra[7]}}, ra[7:0]};
        end else return ST_BADINSN;
        pc = pc + 32'd3;
      end
      OPC_SUBM: begin
        if (b1 != MODRM_SP || b2 != SIB_SP) return ST_BADINSN;
        st = range_chk(sp, 32'd4);
        if (st != ST_OK) return st;
        t = rd_word(sp);
        v = t - ra;
        sub_flags(t, ra, v);
        wr_word(sp, v);
        pc = pc + 32'd3;
      end
      OPC_PUSHA: begin
        t = sp - 32'd4;
        st = range_chk(t, 32'd4);
        if (st != ST_OK) return st;
        wr_word(t, ra);
        sp = t;
        pc = pc + 32'd1;
      end
      OPC_POPA, OPC_POPC, OPC_POPD, OPC_POPB: begin
        st = range_chk(sp, 32'd4);
        if (st != ST_OK) return st;
        v = rd_word(sp);
        sp = sp + 32'd4;
        if (b0 == OPC_POPA) ra = v;
        else if (b0 == OPC_POPC) rc = v;
        else if (b0 == OPC_POPD) rd = v;
        else rb = v;
        pc = pc + 32'd1;
      end
      OPC_JZ, OPC_JNZ: begin
        t = pc + 32'd2;
        if ((b0 == OPC_JZ) == zf) t = t + {{24{b1[7]}}, b1};
        pc = t;
      end
      OPC_SUBI: begin
        if (b1 != MODRM_BP) return ST_BADINSN;
        t = fp;
        v = rd_word(pc + 32'd2);
        fp = t - v;
        sub_flags(t, v, fp);
        pc = pc + 32'd6;
      end
      OPC_TEST: begin
        if (b1 != MODRM_AL) return ST_BADINSN;
        zf = (ra == 32'd0);
        sf = ra[31];
        of = 1'b0;
        pc = pc + 32'd2;
      end
      OPC_XCHG: begin
        if (b1 != MODRM_XCH) return ST_BADINSN;
        t = fp; fp = sp; sp = t;
        pc = pc + 32'd2;
      end
      OPC_MOVB: begin
        if (b1 != MODRM_CL) return ST_BADINSN;
        st = range_chk(ra, 32'd1);
        if (st != ST_OK) return st;
        mem[ra[15:0]] = rc[7:0];
        pc = pc + 32'd2;
      end
      OPC_MOVSP: begin
        if (b1 != MODRM_MOV) return ST_BADINSN;
        fp = sp;
        pc = pc + 32'd2;
      end
      OPC_LDW: begin
        if (b1 != MODRM_EAX) return ST_BADINSN;
        st = range_chk(ra, 32'd4);
        if (st != ST_OK) return st;
        ra = rd_word(ra);
        pc = pc + 32'd2;
      end
      OPC_POPM: begin
        if (b1 != MODRM_EAX) return ST_BADINSN;
        st = range_chk(sp, 32'd4);
        if (st != ST_OK) return st;
        st = range_chk(ra, 32'd4);
        if (st != ST_OK) return st;
        v = rd_word(sp);
        sp = sp + 32'd4;
        wr_word(ra, v);
        pc = pc + 32'd2;
      end
      OPC_MOVI: begin
        ra = rd_word(pc + 32'd1);
        pc = pc + 32'd5;
      end
      OPC_RET: begin
        st = range_chk(sp, 32'd4);
        if (st != ST_OK) return st;
        pc = rd_word(sp);
        sp = sp + 32'd4;
      end
      OPC_INT: begin
        if (b1 != INT_VEC) return ST_BADINSN;
        if (ra == SYS_EXIT) begin
          pc = pc + 32'd2;
          hlt = 1'b1;
          return ST_EXIT;
        end
        if (ra != SYS_READ && ra != SYS_WRITE) return ST_BADSYS;
        st = range_chk(rc, rd);
        if (st != ST_OK) return st;
        pc = pc + 32'd2;
        return (ra == SYS_READ) ? ST_READ : ST_WRITE;
      end
      OPC_CALL: begin
        t = sp - 32'd4;
        st = range_chk(t, 32'd4);
        if (st != ST_OK) return st;
        v = rd_word(pc + 32'd1);
        wr_word(t, pc + 32'd5);
        sp = t;
        pc = pc + 32'd5 + v;
      end
      OPC_DEC: begin
        if (b1 != MODRM_DEC) return ST_BADINSN;
        t = {24'd0, ra[7:0]};
        v = (t - 32'd1) & 32'hFF;
        ra = {ra[31:8], v[7:0]};
        zf = (v == 32'd0);
        sf = v[7];
        of = (t == 32'h80);
        pc = pc + 32'd2;
      end
      default: return ST_BADINSN;
    endcase
    return ST_OK;
  endfunction

  function automatic result_t apply_item(op_e op, logic [15:0] a, logic [7:0] d);
    result_t r;
    status_e st;
    st = ST_OK;
    case (op)
      OP_LOAD: mem[a] = d;
      OP_START: begin
        pc = {16'd0, entry_r};
        sp = {15'd0, limit_r};
        fp = sp;
        ra = '0; rb = '0; rc = '0; rd = '0;
        zf = 1'b0; sf = 1'b0; of = 1'b0;
        hlt = 1'b0;
      end
      OP_STEP: begin
        if (hlt) st = ST_HALTED;
        else begin
          st = exec_instr();
          if (st >= ST_LIMIT) hlt = 1'b1;
        end
      end
      default: ;
    endcase
    r.status = st;
    r.pc = pc; r.a = ra; r.b = rb; r.c = rc; r.d = rd;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    result_t w;
    if (rst_ni && pop && !empty) begin
      if (exp_q.size() == 0)
        report_mismatch("unexpected result, status", 32'(status_o), 32'd0);
      else begin
        w = exp_q.pop_front();
        if (status_o != w.status)
          report_mismatch("status", 32'(status_o), 32'(w.status));
        if (instr_addr_o != w.pc) report_mismatch("instr_addr", instr_addr_o, w.pc);
        if (acc_value_o != w.a) report_mismatch("acc_value", acc_value_o, w.a);
        if (arg_b_o != w.b) report_mismatch("arg_b", arg_b_o, w.b);
        if (arg_c_o != w.c) report_mismatch("arg_c", arg_c_o, w.c);
        if (arg_d_o != w.d) report_mismatch("arg_d", arg_d_o, w.d);
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic xfer(op_e op, logic [15:0] a, logic [7:0] d, bit typed = 1'b0,
                      status_e t_st = ST_OK, logic [31:0] t_pc = '0);
    result_t r;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    operation_i <= op;
    load_address_i <= a;
    load_byte_i <= d;
    do @(posedge clk_i); while (full);
    r = apply_item(op, a, d);
    if (typed) begin
      r.status = t_st;
      r.pc = t_pc;
    end
    exp_q.push_back(r);
    items_sent++;
  endtask

  // sender pause: nothing offered until every result is back
  task automatic drain();
    push <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_cfg(logic [15:0] ent, logic [16:0] lim);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_ENTRY;
    cfg_data_i <= {1'b0, ent};
    @(posedge clk_i);
    entry_r = ent;
    cfg_idx_i <= CFG_LIMIT;
    cfg_data_i <= lim;
    @(posedge clk_i);
    limit_r = lim;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_addr();
    if (limit_r < 17'd4104) return 32'd4096;
    return $urandom_range(limit_r - 8, 4096);
  endfunction

  function automatic void put32(logic [31:0] v);
    for (int i = 0; i < 4; i++) prog_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void gen_insn();
    int k;
    logic [31:0] v;
    k = $urandom_range(0, 26);
    case (k)
      0, 1, 2: begin
        prog_q.push_back(OPC_MOVI);
        case ($urandom_range(0, 4))
          0, 1: v = pick_addr();
          2: v = SYS_EXIT;
          3: v = ($urandom_range(1)) ? SYS_READ : SYS_WRITE;
          default: v = $urandom;
        endcase
        put32(v);
      end
      3, 4: prog_q.push_back(OPC_PUSHA);
      5: prog_q.push_back(OPC_POPA);
      6: prog_q.push_back(OPC_POPB);
      7: prog_q.push_back(OPC_POPC);
      8: prog_q.push_back(OPC_POPD);
      9: begin
        prog_q.push_back(OPC_0F);
        case ($urandom_range(0, 2))
          0: begin prog_q.push_back(SUB_SETGE); prog_q.push_back(MODRM_AL); end
          1: begin prog_q.push_back(SUB_MOVZB); prog_q.push_back(MODRM_EAX); end
          default: begin prog_q.push_back(SUB_MOVSB); prog_q.push_back(MODRM_AL); end
        endcase
      end
      10: begin prog_q.push_back(OPC_SUBM); prog_q.push_back(MODRM_SP);
                prog_q.push_back(SIB_SP); end
      11: begin
        prog_q.push_back(($urandom_range(1)) ? OPC_JZ : OPC_JNZ);
        prog_q.push_back(($urandom_range(3) != 0) ? 8'($urandom_range(6)) : 8'($urandom));
      end
      12: begin
        prog_q.push_back(OPC_SUBI); prog_q.push_back(MODRM_BP);
        put32(($urandom_range(1)) ? 32'($urandom_range(16)) : $urandom);
      end
      13: begin prog_q.push_back(OPC_TEST); prog_q.push_back(MODRM_AL); end
      14: begin prog_q.push_back(OPC_XCHG); prog_q.push_back(MODRM_XCH); end
      15: begin prog_q.push_back(OPC_MOVB); prog_q.push_back(MODRM_CL); end
      16: begin prog_q.push_back(OPC_MOVSP); prog_q.push_back(MODRM_MOV); end
      17: begin prog_q.push_back(OPC_LDW); prog_q.push_back(MODRM_EAX); end
      18: begin prog_q.push_back(OPC_POPM); prog_q.push_back(MODRM_EAX); end
      19: prog_q.push_back(OPC_RET);
      20, 21: begin prog_q.push_back(OPC_INT); prog_q.push_back(INT_VEC); end
      22: begin
        prog_q.push_back(OPC_CALL);
        put32(($urandom_range(3) != 0) ? 32'($urandom_range(8)) : $urandom);
      end
      23, 24: begin prog_q.push_back(OPC_DEC); prog_q.push_back(MODRM_DEC); end
      25: begin
        // known opcode with a broken operand byte
        prog_q.push_back(OPC_INT); prog_q.push_back(8'($urandom));
      end
      default: prog_q.push_back(8'($urandom));
    endcase
  endfunction

  task automatic run_program();
    int n;
    int steps;
    n = $urandom_range(4, 16);
    prog_q.delete();
    for (int i = 0; i < n; i++) gen_insn();
    foreach (prog_q[i]) begin
      if ($urandom_range(9) == 0)
        xfer(op_e'($urandom_range(3)), 16'($urandom), 8'($urandom));
      xfer(OP_LOAD, entry_r + 16'(i), prog_q[i]);
    end
    xfer(OP_START, 16'($urandom), 8'($urandom));
    steps = n + $urandom_range(0, 8);
    for (int i = 0; i < steps; i++) xfer(OP_STEP, 16'($urandom), 8'($urandom));
  endtask

  typedef struct {
    op_e         op;
    logic [15:0] a;
    logic [7:0]  d;
    bit          typed;
    status_e     st;
    logic [31:0] pc;
  } row_t;

  row_t dir_rows[22];

  initial begin
    // shadow state after reset
    for (int i = 0; i < 65536; i++) mem[i] = 8'd0;
    ra = '0; rb = '0; rc = '0; rd = '0; sp = '0; fp = '0; pc = '0;
    zf = 1'b0; sf = 1'b0; of = 1'b0; hlt = 1'b1;
    entry_r = ENTRY_RST;
    limit_r = LIMIT_RST;

    // 0x80 in al, dec overflows, setge then clears al, int with syscall 0 faults
    dir_rows = '{
      '{OP_STEP,  16'h0000, 8'h00, 1'b1, ST_HALTED, 32'd0},
      '{OP_NOP,   16'hFFFF, 8'hFF, 1'b1, ST_OK,     32'd0},
      '{OP_LOAD,  16'h0000, 8'hFF, 1'b1, ST_OK,     32'd0},
      '{OP_LOAD,  16'hFFFF, 8'hFF, 1'b1, ST_OK,     32'd0},
      '{OP_LOAD,  16'h1000, OPC_MOVI, 1'b0, ST_OK, 32'd0},
      '{OP_LOAD,  16'h1001, 8'h80, 1'b0, ST_OK, 32'd0},
      '{OP_LOAD,  16'h1002, 8'h00, 1'b0, ST_OK, 32'd0},
      '{OP_LOAD,  16'h1003, 8'h00, 1'b0, ST_OK, 32'd0},
      '{OP_LOAD,  16'h1004, 8'h00, 1'b0, ST_OK, 32'd0},
      '{OP_LOAD,  16'h1005, OPC_DEC, 1'b0, ST_OK, 32'd0},
      '{OP_LOAD,  16'h1006, MODRM_DEC, 1'b0, ST_OK, 32'd0},
      '{OP_LOAD,  16'h1007, OPC_0F, 1'b0, ST_OK, 32'd0},
      '{OP_LOAD,  16'h1008, SUB_SETGE, 1'b0, ST_OK, 32'd0},
      '{OP_LOAD,  16'h1009, MODRM_AL, 1'b0, ST_OK, 32'd0},
      '{OP_LOAD,  16'h100A, OPC_INT, 1'b0, ST_OK, 32'd0},
      '{OP_LOAD,  16'h100B, INT_VEC, 1'b0, ST_OK, 32'd0},
      '{OP_START, 16'h0000, 8'h00, 1'b1, ST_OK, 32'd4096},
      '{OP_STEP,  16'h0000, 8'h00, 1'b0, ST_OK, 32'd0},
      '{OP_STEP,  16'h0000, 8'h00, 1'b0, ST_OK, 32'd0},
      '{OP_STEP,  16'h0000, 8'h00, 1'b0, ST_OK, 32'd0},
      '{OP_STEP,  16'h0000, 8'h00, 1'b1, ST_BADSYS, 32'd4106},
      '{OP_STEP,  16'h0000, 8'h00, 1'b1, ST_HALTED, 32'd4106}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      xfer(dir_rows[i].op, dir_rows[i].a, dir_rows[i].d, dir_rows[i].typed,
           dir_rows[i].st, dir_rows[i].pc);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: set_cfg(16'd4096, 17'd65536);
        1: set_cfg(16'd65535, 17'd65536);
        2: set_cfg(16'd4096, 17'd4096);
        3: set_cfg(16'd12288, 17'd16384);
        default: set_cfg(16'($urandom_range(65000, 4096)), 17'($urandom_range(65536, 4096)));
      endcase
      if (ph < 2) begin send_idle = 28; recv_idle = 57; end
      else if (ph < 4) begin send_idle = 57; recv_idle = 28; end
      else begin send_idle = 0; recv_idle = 0; end
      if (ph == 3) hold_left = 400;
      while (items_sent < 22 + (ph + 1) * 222) run_program();
    end

    drain();
    if (err_cnt == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #8ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/x86ex_pkg.sv
rtl/core/x86ex_ram.sv
rtl/core/x86ex_front.sv
rtl/core/x86ex_back.sv
rtl/core/x86_subset_instruction_executor_unit.sv
tb/tb_top.sv
